[hdl/pdgc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdgc_pkg
// Shared types, constants and the sine table builder for the PD torque block.
// ----------------------------------------------------------------------------
package pdgc_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NUM_STAGES       = 5;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Register map
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_ON    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_SHOULDER = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_ELBOW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_WRIST    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_KV_GAIN       = 3'd6;

    typedef enum logic [1:0] {
        MODE_GRAVITY    = 2'd0,
        MODE_P          = 2'd1,
        MODE_P_GRAVITY  = 2'd2,
        MODE_PD_GRAVITY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              control_mode;
        logic               gravity_on;
        logic signed [15:0] coef_shoulder;
        logic signed [15:0] coef_elbow;
        logic signed [15:0] coef_wrist;
        logic        [15:0] kp_gain;
        logic        [15:0] kv_gain;
    } pdgc_cfg_t;

    typedef struct packed {
        logic        [15:0] angle_one;
        logic        [15:0] angle_two;
        logic        [15:0] angle_three;
        logic        [15:0] target_one;
        logic        [15:0] target_two;
        logic        [15:0] target_three;
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
        logic signed [15:0] speed_three;
    } pdgc_in_t;

    typedef struct packed {
        logic signed [31:0] torque_one;
        logic signed [31:0] torque_two;
        logic signed [31:0] torque_three;
    } pdgc_out_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
        logic [NUM_STAGES-1:0] vld;
    } pdgc_pipe_t;

    typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // shift-subtract quotient used while building the table
    function automatic longint unsigned rom_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q15 quarter-wave sine, Taylor series in Q30 through x^25
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint unsigned    pos;
        longint unsigned    neg;
        longint unsigned    res;
        longint unsigned    divs [1:12];
        divs[1]  = 64'd6;
        divs[2]  = 64'd20;
        divs[3]  = 64'd42;
        divs[4]  = 64'd72;
        divs[5]  = 64'd110;
        divs[6]  = 64'd156;
        divs[7]  = 64'd210;
        divs[8]  = 64'd272;
        divs[9]  = 64'd342;
        divs[10] = 64'd420;
        divs[11] = 64'd506;
        divs[12] = 64'd600;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k <= 12; k++)
            begin
                term = rom_udiv((term * x2) >> 30, divs[k]);
                if ((k % 2) == 1)
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
            res    = (pos >= neg) ? (pos - neg) : 64'd0;
            rom[i] = 16'((res + 64'd16384) >> 15);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

[hdl/pd_gravity_compensated_joint_torque.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pd_gravity_compensated_joint_torque
// PD joint torque with gravity compensation for a planar three-link arm.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  in_data  (pdgc_in_t)
//   out       output     out_valid / out_stall out_data (pdgc_out_t)
//   cfg       input      cfg_wr_en            cfg_addr, cfg_wdata
//
// Five-stage pipeline: angle sums and errors, sine table read with gain
// multiplies, gravity multiplies, gravity sums, torque add and saturate.
// One beat per cycle unless the output stalls; each beat is registered in every stage in turn.
// Each stage advances when its successor is empty or moving, so a stalled
// output still lets beats fill empty stages behind it.
// Reset clears valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pd_gravity_compensated_joint_torque
    import pdgc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pdgc_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output pdgc_out_t                  out_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic signed [32:0] GRAV_ROUND = 33'sd16384;
    localparam logic signed [35:0] TAU_MAX    = 36'sd2147483647;
    localparam logic signed [35:0] TAU_MIN    = -36'sd2147483648;

    pdgc_cfg_t  cfg;
    pdgc_pipe_t pipe;

    pdgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdgc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pipe      (pipe)
    );

    // stage 1: angle sums, wrapped errors
    logic        [15:0] ang_next   [3];
    logic        [15:0] ang_reg    [3];
    logic signed [15:0] err_next   [3];
    logic signed [15:0] err_reg    [3];
    logic signed [15:0] spd_next   [3];
    logic signed [15:0] spd_reg    [3];
    logic        [15:0] a12;

    always_comb
    begin
        a12         = in_data.angle_one + in_data.angle_two;
        ang_next[0] = in_data.angle_one + QUARTER_TURN;
        ang_next[1] = a12;
        ang_next[2] = a12 + in_data.angle_three;
        err_next[0] = $signed(in_data.target_one - in_data.angle_one);
        err_next[1] = $signed(in_data.target_two - in_data.angle_two);
        err_next[2] = $signed(in_data.target_three - in_data.angle_three);
        spd_next[0] = in_data.speed_one;
        spd_next[1] = in_data.speed_two;
        spd_next[2] = in_data.speed_three;
    end

    always_ff @(posedge clk)
    begin
        if (pipe.adv[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                ang_reg[j] <= ang_next[j];
                err_reg[j] <= err_next[j];
                spd_reg[j] <= spd_next[j];
            end
        end
    end

    // stage 2: sine lookups, proportional and damping products
    logic signed [16:0] sine [3];
    logic signed [32:0] p_next [3];
    logic signed [32:0] p_reg  [3];
    logic signed [32:0] d_next [3];
    logic signed [32:0] d_reg  [3];

    for (genvar j = 0; j < 3; j++)
    begin : g_sine
        pdgc_sine_rom u_sine (
            .clk   (clk),
            .en    (pipe.adv[1]),
            .angle (ang_reg[j]),
            .sine  (sine[j])
        );
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            p_next[j] = 33'($signed({1'b0, cfg.kp_gain})) * 33'(err_reg[j]);
            d_next[j] = 33'($signed({1'b0, cfg.kv_gain})) * 33'(spd_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.adv[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_reg[j] <= p_next[j];
                d_reg[j] <= d_next[j];
            end
        end
    end

    // stage 3: gravity products, mode-selected feedback term
    logic signed [32:0] gprod_next [3];
    logic signed [32:0] gprod_reg  [3];
    logic signed [34:0] fb_next    [3];
    logic signed [34:0] fb_reg     [3];

    always_comb
    begin
        gprod_next[0] = 33'(cfg.coef_shoulder) * 33'(sine[0]);
        gprod_next[1] = 33'(cfg.coef_elbow) * 33'(sine[1]);
        gprod_next[2] = 33'(cfg.coef_wrist) * 33'(sine[2]);
        for (int j = 0; j < 3; j++)
        begin
            case (cfg.control_mode)
                MODE_GRAVITY:    fb_next[j] = '0;
                MODE_P:          fb_next[j] = 35'(p_reg[j]);
                MODE_P_GRAVITY:  fb_next[j] = 35'(p_reg[j]);
                MODE_PD_GRAVITY: fb_next[j] = 35'(p_reg[j]) - 35'(d_reg[j]);
                default:         fb_next[j] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.adv[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                gprod_reg[j] <= gprod_next[j];
                fb_reg[j]    <= fb_next[j];
            end
        end
    end

    // stage 4: round to Q8.8 and accumulate gravity from the wrist inward
    logic signed [32:0] gsum  [3];
    logic signed [17:0] gterm [3];
    logic signed [19:0] g_next [3];
    logic signed [19:0] g_reg  [3];
    logic signed [34:0] fb4_reg [3];
    logic               grav_en;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            gsum[j]  = gprod_reg[j] + GRAV_ROUND;
            gterm[j] = gsum[j][32:15];
        end
        grav_en = cfg.gravity_on && (cfg.control_mode != MODE_P);
        g_next[2] = 20'(gterm[2]);
        g_next[1] = g_next[2] + 20'(gterm[1]);
        g_next[0] = g_next[1] + 20'(gterm[0]);
        if (!grav_en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                g_next[j] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.adv[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                g_reg[j]   <= g_next[j];
                fb4_reg[j] <= fb_reg[j];
            end
        end
    end

    // stage 5: final sum and saturation
    logic signed [35:0] tau    [3];
    logic signed [31:0] tq_next [3];
    logic signed [31:0] tq_reg  [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tau[j] = 36'(fb4_reg[j]) + 36'(g_reg[j]);
            if (tau[j] > TAU_MAX)
            begin
                tq_next[j] = TAU_MAX[31:0];
            end
            else if (tau[j] < TAU_MIN)
            begin
                tq_next[j] = TAU_MIN[31:0];
            end
            else
            begin
                tq_next[j] = tau[j][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.adv[4])
        begin
            for (int j = 0; j < 3; j++)
            begin
                tq_reg[j] <= tq_next[j];
            end
        end
    end

    assign out_data.torque_one   = tq_reg[0];
    assign out_data.torque_two   = tq_reg[1];
    assign out_data.torque_three = tq_reg[2];

    // gravity-only law with gravity off drives zero torque
    a_zero_torque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cfg.control_mode == MODE_GRAVITY) && !cfg.gravity_on |->
        (out_data.torque_one == '0) && (out_data.torque_two == '0) &&
        (out_data.torque_three == '0))
        else $error("nonzero torque with gravity off in gravity-only mode");

endmodule
`default_nettype wire

[hdl/pdgc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdgc_cfg_regs
// Configuration register file: mode, gravity enable, coefficients, gains.
// ----------------------------------------------------------------------------
module pdgc_cfg_regs
    import pdgc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output pdgc_cfg_t                  cfg
);

    pdgc_cfg_t cfg_reg;
    pdgc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CONTROL_MODE:  cfg_next.control_mode  = mode_t'(cfg_wdata[1:0]);
                REG_GRAVITY_ON:    cfg_next.gravity_on    = cfg_wdata[0];
                REG_COEF_SHOULDER: cfg_next.coef_shoulder = $signed(cfg_wdata);
                REG_COEF_ELBOW:    cfg_next.coef_elbow    = $signed(cfg_wdata);
                REG_COEF_WRIST:    cfg_next.coef_wrist    = $signed(cfg_wdata);
                REG_KP_GAIN:       cfg_next.kp_gain       = cfg_wdata;
                REG_KV_GAIN:       cfg_next.kv_gain       = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_mode  <= MODE_GRAVITY;
            cfg_reg.gravity_on    <= 1'b1;
            cfg_reg.coef_shoulder <= '0;
            cfg_reg.coef_elbow    <= '0;
            cfg_reg.coef_wrist    <= '0;
            cfg_reg.kp_gain       <= '0;
            cfg_reg.kv_gain       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hdl/pdgc_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdgc_sine_rom
// Binary angle to signed Q15 sine through a quarter-wave table, registered.
// ----------------------------------------------------------------------------
module pdgc_sine_rom
    import pdgc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic        [15:0] angle,
    output logic signed      [16:0] sine
);

    localparam int PROD_W = 14 + SINE_IDX_W;
    localparam sine_rom_t ROM = build_sine_rom();

    logic        [PROD_W-1:0]     prod;
    logic        [SINE_IDX_W-1:0] n;
    logic        [SINE_IDX_W-1:0] idx;
    logic        [15:0]           mag;
    logic signed [16:0]           sine_next;
    logic signed [16:0]           sine_reg;

    always_comb
    begin
        prod = PROD_W'(angle[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
        n    = prod[PROD_W-1:14];
        idx  = angle[14] ? (SINE_IDX_W'(SINE_TABLE_DEPTH) - n) : n;
        mag  = ROM[idx];
        sine_next = angle[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

[hdl/pdgc_pipe_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdgc_pipe_ctrl
// Per-stage valid bits and advance chain for the five-stage datapath.
// ----------------------------------------------------------------------------
module pdgc_pipe_ctrl
    import pdgc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output pdgc_pipe_t pipe
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;
    logic                  in_acc;
    logic                  out_acc;

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign pipe.adv  = adv;
    assign pipe.vld  = vld_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    // beats in flight track accepted minus delivered
    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(vld_reg) ==
         $past($countones(vld_reg)) + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline beat count mismatch");

    // the fourth stage keeps its beat while the last stage is held
    a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NUM_STAGES-2] && !adv[NUM_STAGES-1] |=> vld_reg[NUM_STAGES-2])
        else $error("held beat dropped");

    // a full pipe with a stalled output takes no input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && out_stall |-> in_stall)
        else $error("input taken while pipe full");

endmodule
`default_nettype wire
